// ----- hw/rtl/voronoi_nearest_seed_pixel_unit_assert.svh -----
// Assertion macros for the voronoi nearest seed pixel unit.
// Used by vnsp_ctrl and vnsp_datapath; expects clk and rst_n in scope.
`ifndef VORONOI_NEAREST_SEED_PIXEL_UNIT_ASSERT_SVH
`define VORONOI_NEAREST_SEED_PIXEL_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked property, disabled while reset is asserted.
`define VNSP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("vnsp assertion failed");

// Checked property that also holds during reset.
`define VNSP_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("vnsp assertion failed");

`else

`define VNSP_ASSERT(lbl, prop)
`define VNSP_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ----- hw/rtl/vnsp_pkg.sv -----
// Shared constants, opcodes and control structs of the voronoi pixel unit.
// No dependencies; used by every other RTL file except the assertion macro header.
`default_nettype none

package vnsp_pkg;

    localparam int OP_W         = 2;
    localparam int COORD_W      = 8;
    localparam int COLOUR_W     = 8;
    localparam int PIX_W        = 10;
    localparam int OUT_COLOUR_W = 11;
    localparam int COLOUR_SHIFT = 3;
    localparam int DIST_W       = 28;

    localparam logic [DIST_W-1:0] DIST_LIMIT = 28'h800_0000;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam int MAX_SEEDS_DEFAULT = 256;
    localparam int SCALE_DEFAULT     = 4;

    // controller -> datapath
    typedef struct packed {
        logic start_query;
        logic append;
        logic clear;
        logic rd_en;
        logic publish;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic busy;
        logic full;
        logic out_full;
    } sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/vnsp_if.sv -----
// Valid/ready channel interfaces for request and response transactions.
// Field widths come from vnsp_pkg.
`default_nettype none

interface vnsp_req_if;
    logic                               valid;
    logic                               ready;
    logic [vnsp_pkg::OP_W-1:0]          operation;
    logic [vnsp_pkg::COORD_W-1:0]       delta_x;
    logic [vnsp_pkg::COORD_W-1:0]       delta_y;
    logic [vnsp_pkg::COLOUR_W-1:0]      seed_colour;
    logic [vnsp_pkg::PIX_W-1:0]         pixel_x;
    logic [vnsp_pkg::PIX_W-1:0]         pixel_y;

    modport source (output valid, operation, delta_x, delta_y, seed_colour,
                    pixel_x, pixel_y, input ready);
    modport sink   (input valid, operation, delta_x, delta_y, seed_colour,
                    pixel_x, pixel_y, output ready);
endinterface

interface vnsp_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [vnsp_pkg::OUT_COLOUR_W-1:0]  pixel_colour;
    logic                               found;

    modport source (output valid, pixel_colour, found, input ready);
    modport sink   (input valid, pixel_colour, found, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/voronoi_nearest_seed_pixel_unit.sv -----
// Top level of the voronoi nearest seed pixel unit: controller plus datapath.
// Depends on vnsp_pkg, vnsp_if, vnsp_ctrl and vnsp_datapath.
`default_nettype none

// Append and clear transactions are accepted in the idle state and leave the controller
// idle. A query walks the seed table through the single read port of the seed memory,
// one seed per cycle: table read, three pipeline stages for difference, square and
// compare, then the response register. The response register holds a finished result
// until taken; append and clear transactions are still accepted meanwhile, and a
// following query waits only at its end if the previous response has not been taken.
// The seed memory has no reset; only entries below the current seed count are ever
// used in a query.
module voronoi_nearest_seed_pixel_unit #(
    parameter int MAX_SEEDS = vnsp_pkg::MAX_SEEDS_DEFAULT,
    parameter int SCALE     = vnsp_pkg::SCALE_DEFAULT
) (
    input  wire         clk,
    input  wire         rst_n,
    vnsp_req_if.sink    req,
    vnsp_rsp_if.source  rsp
);

    localparam int CNT_W = $clog2(MAX_SEEDS + 1);
    localparam int IDX_W = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;

    vnsp_pkg::cmd_t   cmd;
    vnsp_pkg::sts_t   sts;
    logic [IDX_W-1:0] rd_addr;
    logic [CNT_W-1:0] seed_count;

    vnsp_ctrl #(
        .MAX_SEEDS (MAX_SEEDS),
        .CNT_W     (CNT_W),
        .IDX_W     (IDX_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_ready   (req.ready),
        .operation  (req.operation),
        .seed_count (seed_count),
        .sts        (sts),
        .cmd        (cmd),
        .rd_addr    (rd_addr)
    );

    vnsp_datapath #(
        .MAX_SEEDS (MAX_SEEDS),
        .SCALE     (SCALE),
        .CNT_W     (CNT_W),
        .IDX_W     (IDX_W)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .rd_addr      (rd_addr),
        .delta_x      (req.delta_x),
        .delta_y      (req.delta_y),
        .seed_colour  (req.seed_colour),
        .pixel_x      (req.pixel_x),
        .pixel_y      (req.pixel_y),
        .sts          (sts),
        .seed_count   (seed_count),
        .rsp_valid    (rsp.valid),
        .rsp_ready    (rsp.ready),
        .pixel_colour (rsp.pixel_colour),
        .found        (rsp.found)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/vnsp_ctrl.sv -----
// Controller FSM: takes request transactions, sequences the seed table walk.
// Depends on vnsp_pkg and the assertion macro header.
`default_nettype none
`include "voronoi_nearest_seed_pixel_unit_assert.svh"

module vnsp_ctrl #(
    parameter int MAX_SEEDS = vnsp_pkg::MAX_SEEDS_DEFAULT,
    parameter int CNT_W     = $clog2(MAX_SEEDS + 1),
    parameter int IDX_W     = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         in_valid,
    output logic                        in_ready,
    input  wire [vnsp_pkg::OP_W-1:0]    operation,
    input  wire [CNT_W-1:0]             seed_count,
    input  vnsp_pkg::sts_t              sts,
    output vnsp_pkg::cmd_t              cmd,
    output logic [IDX_W-1:0]            rd_addr
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign rd_addr  = idx_reg[IDX_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (operation)
                        vnsp_pkg::OP_APPEND: cmd.append = !sts.full;
                        vnsp_pkg::OP_CLEAR:  cmd.clear  = 1'b1;
                        vnsp_pkg::OP_QUERY:
                        begin
                            cmd.start_query = 1'b1;
                            idx_next        = '0;
                            state_next      = ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                // one table read per cycle
                if (idx_reg == seed_count)
                    state_next = ST_DRAIN;
                else
                begin
                    cmd.rd_en = 1'b1;
                    idx_next  = idx_reg + CNT_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!sts.busy && !sts.out_full)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    `VNSP_ASSERT(a_rd_in_range, cmd.rd_en |-> (idx_reg < seed_count))
    `VNSP_ASSERT(a_publish_drained, cmd.publish |-> !sts.busy)
    `VNSP_ASSERT(a_idle_pipe_empty, (state_reg == ST_IDLE) |-> !sts.busy)

endmodule

`default_nettype wire

// ----- hw/rtl/vnsp_datapath.sv -----
// Datapath: seed memory, running sums, distance pipeline, best tracker, output reg.
// Depends on vnsp_pkg and the assertion macro header.
`default_nettype none
`include "voronoi_nearest_seed_pixel_unit_assert.svh"

module vnsp_datapath #(
    parameter int MAX_SEEDS = vnsp_pkg::MAX_SEEDS_DEFAULT,
    parameter int SCALE     = vnsp_pkg::SCALE_DEFAULT,
    parameter int CNT_W     = $clog2(MAX_SEEDS + 1),
    parameter int IDX_W     = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  vnsp_pkg::cmd_t                      cmd,
    input  wire [IDX_W-1:0]                     rd_addr,
    input  wire [vnsp_pkg::COORD_W-1:0]         delta_x,
    input  wire [vnsp_pkg::COORD_W-1:0]         delta_y,
    input  wire [vnsp_pkg::COLOUR_W-1:0]        seed_colour,
    input  wire [vnsp_pkg::PIX_W-1:0]           pixel_x,
    input  wire [vnsp_pkg::PIX_W-1:0]           pixel_y,
    output vnsp_pkg::sts_t                      sts,
    output logic [CNT_W-1:0]                    seed_count,
    output logic                                rsp_valid,
    input  wire                                 rsp_ready,
    output logic [vnsp_pkg::OUT_COLOUR_W-1:0]   pixel_colour,
    output logic                                found
);

    localparam int CW     = vnsp_pkg::COORD_W;
    localparam int KW     = vnsp_pkg::COLOUR_W;
    localparam int PW     = vnsp_pkg::PIX_W;
    localparam int DW     = vnsp_pkg::DIST_W;
    localparam int SX_W   = $clog2(255 * SCALE + 1);
    localparam int DIFF_W = ((SX_W > PW) ? SX_W : PW) + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int SUM_W  = SQ_W + 1;

    typedef struct packed {
        logic [KW-1:0] colour;
        logic [CW-1:0] y;
        logic [CW-1:0] x;
    } seed_t;

    seed_t seed_mem [MAX_SEEDS];
    seed_t mem_q;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CW-1:0]    rx_reg, rx_next, ry_reg, ry_next;
    logic [PW-1:0]    qx_reg, qy_reg;

    logic                     v1_reg, v2_reg, v3_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dx_next, dy_next;
    logic [KW-1:0]            col2_reg, col3_reg;
    logic [SQ_W-1:0]          sqx_reg, sqy_reg;
    logic signed [SQ_W-1:0]   prod_x, prod_y;
    logic [SX_W-1:0]          sx, sy;
    logic [SUM_W-1:0]         dist_sum;
    logic [DW-1:0]            dist_ext;

    logic [DW-1:0] best_reg;
    logic [KW-1:0] best_col_reg;
    logic          best_found_reg;
    logic          take;

    logic                             out_valid_reg;
    logic [vnsp_pkg::OUT_COLOUR_W-1:0] out_colour_reg;
    logic                             out_found_reg;

    // seed table and running sums
    assign rx_next = rx_reg + delta_x;
    assign ry_next = ry_reg + delta_y;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear)
            count_next = '0;
        else if (cmd.append)
            count_next = count_reg + CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.append)
            seed_mem[count_reg[IDX_W-1:0]] <= '{colour: seed_colour, y: ry_next, x: rx_next};
        mem_q <= seed_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            rx_reg    <= '0;
            ry_reg    <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.clear)
            begin
                rx_reg <= '0;
                ry_reg <= '0;
            end
            else if (cmd.append)
            begin
                rx_reg <= rx_next;
                ry_reg <= ry_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_query)
        begin
            qx_reg <= pixel_x;
            qy_reg <= pixel_y;
        end
    end

    // distance pipeline: read -> diff -> square -> compare
    assign sx      = SX_W'(mem_q.x * SCALE);
    assign sy      = SX_W'(mem_q.y * SCALE);
    assign dx_next = $signed(DIFF_W'(sx)) - $signed(DIFF_W'(qx_reg));
    assign dy_next = $signed(DIFF_W'(sy)) - $signed(DIFF_W'(qy_reg));
    assign prod_x  = dx_reg * dx_reg;
    assign prod_y  = dy_reg * dy_reg;
    assign dist_sum = SUM_W'(sqx_reg) + SUM_W'(sqy_reg);
    assign dist_ext = DW'(dist_sum);
    // strict less-than keeps the earlier seed on a tie
    assign take     = v3_reg && (dist_ext < best_reg);

    always_ff @(posedge clk)
    begin
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        col2_reg <= mem_q.colour;
        sqx_reg  <= $unsigned(prod_x);
        sqy_reg  <= $unsigned(prod_y);
        col3_reg <= col2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            best_found_reg <= 1'b0;
            best_reg       <= vnsp_pkg::DIST_LIMIT;
            best_col_reg   <= '0;
        end
        else
        begin
            v1_reg <= cmd.rd_en;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (cmd.start_query)
            begin
                best_found_reg <= 1'b0;
                best_reg       <= vnsp_pkg::DIST_LIMIT;
                best_col_reg   <= '0;
            end
            else if (take)
            begin
                best_found_reg <= 1'b1;
                best_reg       <= dist_ext;
                best_col_reg   <= col3_reg;
            end
        end
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.publish)
            out_valid_reg <= 1'b1;
        else if (rsp_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            out_colour_reg <= {best_col_reg, {vnsp_pkg::COLOUR_SHIFT{1'b0}}};
            out_found_reg  <= best_found_reg;
        end
    end

    assign seed_count   = count_reg;
    assign sts.busy     = v1_reg || v2_reg || v3_reg;
    assign sts.full     = (count_reg == CNT_W'(MAX_SEEDS));
    assign sts.out_full = out_valid_reg;
    assign rsp_valid    = out_valid_reg;
    assign pixel_colour = out_colour_reg;
    assign found        = out_found_reg;

    `VNSP_ASSERT(a_none_found_zero, (out_valid_reg && !out_found_reg) |-> (out_colour_reg == '0))
    `VNSP_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(MAX_SEEDS))

endmodule

`default_nettype wire

// ----- tb/sv/tb_voronoi_nearest_seed_pixel_unit.sv -----
// Self-checking testbench for voronoi_nearest_seed_pixel_unit: drives append, query and
// clear transactions and checks every query response against a built-in nearest-seed model.
// Depends on vnsp_pkg and the vnsp_req_if / vnsp_rsp_if channel interfaces of the RTL.
module tb_voronoi_nearest_seed_pixel_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import vnsp_pkg::*;

    localparam int MAX_SEEDS     = MAX_SEEDS_DEFAULT;
    localparam int SCALE         = SCALE_DEFAULT;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS  = 1150;
    localparam int TOTAL_ITEMS   = 1300;
    localparam int SETTLE_CYCLES = 300;        // full table walk plus pipeline
    localparam int LIMIT_CYCLES  = 3_000_000;

    typedef struct {
        logic [OP_W-1:0]     operation;
        logic [COORD_W-1:0]  delta_x;
        logic [COORD_W-1:0]  delta_y;
        logic [COLOUR_W-1:0] seed_colour;
        logic [PIX_W-1:0]    pixel_x;
        logic [PIX_W-1:0]    pixel_y;
    } req_item_t;

    typedef struct {
        logic [OUT_COLOUR_W-1:0] pixel_colour;
        logic                    found;
    } pixel_answer_t;

    logic clk;
    logic rst_n;

    vnsp_req_if req_ch ();
    vnsp_rsp_if rsp_ch ();

    voronoi_nearest_seed_pixel_unit #(
        .MAX_SEEDS (MAX_SEEDS),
        .SCALE     (SCALE)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // nearest-seed model state
    logic [COORD_W-1:0]  seed_x_mem [MAX_SEEDS];
    logic [COORD_W-1:0]  seed_y_mem [MAX_SEEDS];
    logic [COLOUR_W-1:0] seed_col_mem [MAX_SEEDS];
    int unsigned         seed_total;
    logic [COORD_W-1:0]  sum_x;
    logic [COORD_W-1:0]  sum_y;

    pixel_answer_t answer_q [$];
    int err_count;
    int items_sent;
    int rsp_hold_left;
    bit req_idle_on;
    bit rsp_idle_on;
    int cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_voronoi_nearest_seed_pixel_unit NOT OK");
        $finish;
    end

    function automatic void model_transaction(input req_item_t it);
        longint        best;
        longint        dxs;
        longint        dys;
        longint        dist_sq;
        pixel_answer_t ans;
        case (it.operation)
            OP_APPEND:
                // full table drops the append, running sums included
                if (seed_total < MAX_SEEDS)
                begin
                    sum_x = sum_x + it.delta_x;
                    sum_y = sum_y + it.delta_y;
                    seed_x_mem[seed_total]   = sum_x;
                    seed_y_mem[seed_total]   = sum_y;
                    seed_col_mem[seed_total] = it.seed_colour;
                    seed_total++;
                end
            OP_CLEAR:
            begin
                seed_total = 0;
                sum_x = '0;
                sum_y = '0;
            end
            OP_QUERY:
            begin
                best = longint'(DIST_LIMIT);
                ans.found = 1'b0;
                ans.pixel_colour = '0;
                for (int i = 0; i < seed_total; i++)
                begin
                    dxs     = longint'(seed_x_mem[i]) * SCALE - longint'(it.pixel_x);
                    dys     = longint'(seed_y_mem[i]) * SCALE - longint'(it.pixel_y);
                    dist_sq = dxs * dxs + dys * dys;
                    // strict compare: earlier seed keeps a tie
                    if (dist_sq < best)
                    begin
                        best = dist_sq;
                        ans.pixel_colour = OUT_COLOUR_W'(seed_col_mem[i]) << COLOUR_SHIFT;
                        ans.found = 1'b1;
                    end
                end
                answer_q.push_back(ans);
            end
            default: ;
        endcase
    endfunction

    function automatic void report_mismatch(input string what, input int want, input int got);
        err_count++;
        if (err_count <= 10)
            $display("[%0t] %s mismatch: expected %0d, got %0d", $time, what, want, got);
    endfunction

    initial
    begin : answer_checker
        pixel_answer_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                if (answer_q.size() == 0)
                    report_mismatch("unexpected response, found", -1, rsp_ch.found);
                else
                begin
                    want = answer_q.pop_front();
                    if (rsp_ch.pixel_colour !== want.pixel_colour)
                        report_mismatch("pixel_colour", want.pixel_colour, rsp_ch.pixel_colour);
                    if (rsp_ch.found !== want.found)
                        report_mismatch("found", want.found, rsp_ch.found);
                end
            end
        end
    end

    // response side: a long hold-off when one is set, else random stall bursts
    initial
    begin : rsp_ready_drive
        int stall_left;
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_hold_left > 0)
            begin
                rsp_hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (rsp_idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 18);
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    task automatic send_txn(input req_item_t it);
        if (req_idle_on && $urandom_range(0, 5) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.operation   <= it.operation;
        req_ch.delta_x     <= it.delta_x;
        req_ch.delta_y     <= it.delta_y;
        req_ch.seed_colour <= it.seed_colour;
        req_ch.pixel_x     <= it.pixel_x;
        req_ch.pixel_y     <= it.pixel_y;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        model_transaction(it);
        items_sent++;
    endtask

    // always takes at least one edge, so valid is never lowered and raised in one step
    task automatic wait_for_answers();
        req_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (answer_q.size() != 0);
    endtask

    // unused fields carry random values on every transaction
    function automatic req_item_t random_item(input logic [OP_W-1:0] op);
        req_item_t it;
        it.operation   = op;
        it.delta_x     = COORD_W'($urandom_range(0, 255));
        it.delta_y     = COORD_W'($urandom_range(0, 255));
        it.seed_colour = COLOUR_W'($urandom_range(0, 255));
        it.pixel_x     = PIX_W'($urandom_range(0, 1023));
        it.pixel_y     = PIX_W'($urandom_range(0, 1023));
        return it;
    endfunction

    function automatic req_item_t make_item(input logic [OP_W-1:0] op,
                                            input int dx, input int dy, input int col,
                                            input int px, input int py);
        req_item_t it;
        it = random_item(op);
        if (op == OP_APPEND)
        begin
            it.delta_x     = COORD_W'(dx);
            it.delta_y     = COORD_W'(dy);
            it.seed_colour = COLOUR_W'(col);
        end
        if (op == OP_QUERY)
        begin
            it.pixel_x = PIX_W'(px);
            it.pixel_y = PIX_W'(py);
        end
        return it;
    endfunction

    // query close to a stored seed, so near-ties between clustered seeds get exercised
    function automatic req_item_t aimed_query();
        req_item_t it;
        int        pick;
        it = random_item(OP_QUERY);
        if (seed_total > 0)
        begin
            pick = $urandom_range(0, seed_total - 1);
            it.pixel_x = PIX_W'(int'(seed_x_mem[pick]) * SCALE + int'($urandom_range(0, 6)) - 3);
            it.pixel_y = PIX_W'(int'(seed_y_mem[pick]) * SCALE + int'($urandom_range(0, 6)) - 3);
        end
        return it;
    endfunction

    task automatic test_empty_table();
        send_txn(make_item(OP_QUERY, 0, 0, 0, 0, 0));
        send_txn(make_item(OP_QUERY, 0, 0, 0, 1023, 1023));
        send_txn(random_item(OP_UNUSED));
        send_txn(random_item(OP_CLEAR));
        send_txn(make_item(OP_QUERY, 0, 0, 0, 1023, 0));
    endtask

    task automatic test_directed_basics();
        send_txn(random_item(OP_CLEAR));
        send_txn(make_item(OP_APPEND, 0, 0, 255, 0, 0));
        // same position again: the first seed must win
        send_txn(make_item(OP_APPEND, 0, 0, 0, 0, 0));
        send_txn(make_item(OP_QUERY, 0, 0, 0, 0, 0));
        send_txn(make_item(OP_QUERY, 0, 0, 0, 1023, 1023));
        send_txn(make_item(OP_APPEND, 255, 255, 8'hA5, 0, 0));
        send_txn(make_item(OP_QUERY, 0, 0, 0, 1023, 1023));
        // equidistant from (0,0) and (255,255) scaled
        send_txn(make_item(OP_QUERY, 0, 0, 0, 510, 510));
        send_txn(random_item(OP_UNUSED));
        // running x wraps from 255 to 0
        send_txn(make_item(OP_APPEND, 1, 0, 8'h5A, 0, 0));
        send_txn(make_item(OP_QUERY, 0, 0, 0, 0, 1023));
        send_txn(random_item(OP_CLEAR));
        send_txn(make_item(OP_QUERY, 0, 0, 0, 512, 512));
        send_txn(make_item(OP_APPEND, 128, 64, 1, 0, 0));
        send_txn(make_item(OP_QUERY, 0, 0, 0, 512, 256));
        send_txn(make_item(OP_APPEND, 10, 0, 2, 0, 0));
        // halfway between x=512 and x=552
        send_txn(make_item(OP_QUERY, 0, 0, 0, 532, 256));
        send_txn(make_item(OP_QUERY, 0, 0, 0, 1023, 0));
    endtask

    task automatic test_table_overflow();
        send_txn(random_item(OP_CLEAR));
        repeat (MAX_SEEDS + 3) send_txn(random_item(OP_APPEND));
        repeat (2) send_txn(aimed_query());
        repeat (2) send_txn(random_item(OP_QUERY));
        send_txn(make_item(OP_QUERY, 0, 0, 0, 1023, 1023));
        send_txn(random_item(OP_CLEAR));
        send_txn(random_item(OP_QUERY));
    endtask

    // response side held off while requests keep coming; the second query blocks the input
    task automatic test_response_holdoff();
        rsp_hold_left = 400;
        send_txn(random_item(OP_CLEAR));
        repeat (4) send_txn(random_item(OP_APPEND));
        send_txn(aimed_query());
        send_txn(random_item(OP_APPEND));
        send_txn(random_item(OP_QUERY));
        send_txn(aimed_query());
        send_txn(random_item(OP_APPEND));
        send_txn(random_item(OP_QUERY));
    endtask

    task automatic random_session(input bit allow_idle);
        req_item_t it;
        int        n_seeds;
        req_idle_on = allow_idle && ($urandom_range(0, 3) != 0);
        rsp_idle_on = allow_idle && ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 4) == 0)
        begin
            // noise: any operation code, unused one included
            repeat ($urandom_range(1, 8))
                send_txn(random_item(OP_W'($urandom_range(0, 3))));
        end
        else
        begin
            if ($urandom_range(0, 5) != 0)
                send_txn(random_item(OP_CLEAR));
            n_seeds = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
            repeat (n_seeds)
            begin
                it = random_item(OP_APPEND);
                if ($urandom_range(0, 7) == 0)
                begin
                    it.delta_x = '0;
                    it.delta_y = COORD_W'($urandom_range(0, 1));
                end
                send_txn(it);
            end
            repeat ($urandom_range(1, 8))
            begin
                if ($urandom_range(0, 5) == 0)
                    send_txn(random_item(OP_APPEND));
                if ($urandom_range(0, 1) == 0)
                    send_txn(aimed_query());
                else
                    send_txn(random_item(OP_QUERY));
            end
        end
    endtask

    task automatic test_random_traffic();
        while (items_sent < RANDOM_ITEMS)
            random_session(1'b1);
    endtask

    task automatic test_sender_pause();
        wait_for_answers();
        repeat (SETTLE_CYCLES) @(posedge clk);
        repeat (3) random_session(1'b1);
    endtask

    task automatic test_no_idle();
        wait_for_answers();
        req_idle_on = 1'b0;
        rsp_idle_on = 1'b0;
        while (items_sent < TOTAL_ITEMS)
            random_session(1'b0);
    endtask

    initial
    begin : test_sequence
        err_count     = 0;
        items_sent    = 0;
        rsp_hold_left = 0;
        req_idle_on   = 1'b1;
        rsp_idle_on   = 1'b1;
        seed_total    = 0;
        sum_x         = '0;
        sum_y         = '0;
        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.operation   <= OP_APPEND;
        req_ch.delta_x     <= '0;
        req_ch.delta_y     <= '0;
        req_ch.seed_colour <= '0;
        req_ch.pixel_x     <= '0;
        req_ch.pixel_y     <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_directed_basics();
        test_table_overflow();
        test_response_holdoff();
        test_random_traffic();
        test_sender_pause();
        test_no_idle();

        wait_for_answers();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_count == 0 && answer_q.size() == 0)
            $display("tb_voronoi_nearest_seed_pixel_unit OK");
        else
            $display("tb_voronoi_nearest_seed_pixel_unit NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/vnsp_pkg.sv
hw/rtl/vnsp_if.sv
hw/rtl/vnsp_ctrl.sv
hw/rtl/vnsp_datapath.sv
hw/rtl/voronoi_nearest_seed_pixel_unit.sv
tb/sv/tb_voronoi_nearest_seed_pixel_unit.sv
